@@ hdl/lbpg_pkg.sv @@
// Shared types, mode codes and flash timing tables for the LED blink generator.
`default_nettype none

package lbpg_pkg;

  localparam int DUR_BITS = 16;

  typedef enum logic [2:0] {
    MODE_FLASH5 = 3'd0,
    MODE_FLASH2 = 3'd1,
    MODE_FLASH1 = 3'd2,
    MODE_SLOW   = 3'd3,
    MODE_ON     = 3'd4,
    MODE_OFF    = 3'd5,
    MODE_TIMED  = 3'd6,
    MODE_IDLE   = 3'd7
  } mode_t;

  // Per-channel control for one beat out of the input register.
  typedef struct packed {
    logic                step;
    logic                tick;
    logic                cmd;
    mode_t               mode;
    logic [DUR_BITS-1:0] duration;
  } chan_ctl_t;

  function automatic logic [7:0] start_on(input logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      2'd0: v = 8'd15;
      2'd1: v = 8'd30;
      2'd2: v = 8'd50;
      default: v = 8'd80;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] start_off(input logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      2'd0: v = 8'd5;
      2'd1: v = 8'd20;
      2'd2: v = 8'd50;
      default: v = 8'd120;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] reload_on(input logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      2'd0: v = 8'd15;
      2'd1: v = 8'd30;
      2'd2: v = 8'd80;
      default: v = 8'd100;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] reload_off(input logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      2'd0: v = 8'd5;
      2'd1: v = 8'd20;
      2'd2: v = 8'd20;
      default: v = 8'd100;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/lbpg_channel.sv @@
// One LED channel: mode, on/off counters and drive level, updated per beat.
`default_nettype none

module lbpg_channel
  import lbpg_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire chan_ctl_t ctl,
  output logic           lit
);

  mode_t                 mode;
  mode_t                 mode_next;
  logic [COUNT_BITS-1:0] on_count;
  logic [COUNT_BITS-1:0] on_count_next;
  logic [COUNT_BITS-1:0] off_count;
  logic [COUNT_BITS-1:0] off_count_next;
  logic                  lit_next;
  logic [COUNT_BITS-1:0] on_dec;

  assign on_dec = on_count - COUNT_BITS'(1);

  always_comb begin
    mode_next      = mode;
    on_count_next  = on_count;
    off_count_next = off_count;
    lit_next       = lit;
    if (ctl.step && ctl.tick) begin
      if (!mode[2]) begin
        if (on_count != '0) begin
          on_count_next = on_dec;
          if (on_dec == '0) lit_next = 1'b0;
        end else if (off_count != '0) begin
          off_count_next = off_count - COUNT_BITS'(1);
        end else begin
          on_count_next  = COUNT_BITS'(reload_on(mode[1:0]));
          off_count_next = COUNT_BITS'(reload_off(mode[1:0]));
          lit_next       = 1'b1;
        end
      end else if (mode == MODE_TIMED) begin
        if (on_count == '0) begin
          lit_next  = 1'b0;
          mode_next = MODE_IDLE;
        end else begin
          on_count_next = on_dec;
        end
      end
    end else if (ctl.step && ctl.cmd && (ctl.mode != mode)) begin
      mode_next = ctl.mode;
      unique case (ctl.mode)
        MODE_FLASH5, MODE_FLASH2, MODE_FLASH1, MODE_SLOW: begin
          lit_next       = 1'b1;
          on_count_next  = COUNT_BITS'(start_on(ctl.mode[1:0]));
          off_count_next = COUNT_BITS'(start_off(ctl.mode[1:0]));
        end
        MODE_ON:    lit_next = 1'b1;
        MODE_OFF:   lit_next = 1'b0;
        MODE_TIMED: begin
          lit_next      = 1'b1;
          on_count_next = COUNT_BITS'(ctl.duration);
        end
        default: ;  // idle: keep level and counts
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      on_count  <= '0;
      off_count <= '0;
      lit       <= 1'b0;
    end else begin
      mode      <= mode_next;
      on_count  <= on_count_next;
      off_count <= off_count_next;
      lit       <= lit_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/led_blink_pattern_generator_unit.sv @@
// Throughput: one item per cycle unless a result beat stalls; input register, then channel update into result.
// The LED levels live in the channel state registers and form the result payload.
// Result stall holds both stages; input stalls only if both are full and result stalls.
// Reset (rst, synchronous): all channels idle, counts zero, LEDs off, no beat pending.
`default_nettype none

module led_blink_pattern_generator_unit
  import lbpg_pkg::*;
#(
  parameter int CHANNELS   = 2,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic                func,
  input  wire logic                channel,
  input  wire logic [2:0]          mode,
  input  wire logic [DUR_BITS-1:0] duration,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic                     led0_lit,
  output logic                     led1_lit
);

  logic                s1_valid;
  logic                s1_func;
  logic                s1_channel;
  logic [2:0]          s1_mode;
  logic [DUR_BITS-1:0] s1_duration;
  logic                advance;
  logic                accept;
  logic [CHANNELS-1:0] lit;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= s1_valid;
      end
      // Load the input stage whenever it is empty or drains.
      if (advance || !s1_valid) begin
        s1_valid <= item_valid;
      end
    end
  end

  // Payload of the input stage; hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= func;
      s1_channel  <= channel;
      s1_mode     <= mode;
      s1_duration <= duration;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_ctl_t ctl;

    always_comb begin
      ctl.step     = s1_valid && advance;
      ctl.tick     = !s1_func;
      ctl.cmd      = s1_func && (int'(s1_channel) == c);
      ctl.mode     = mode_t'(s1_mode);
      ctl.duration = s1_duration;
    end

    lbpg_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_chan (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .lit(lit[c])
    );
  end

  assign led0_lit = lit[0];

  if (CHANNELS > 1) begin : g_led1
    assign led1_lit = lit[1];
  end else begin : g_no_led1
    assign led1_lit = 1'b0;
  end

endmodule

`default_nettype wire

@@ hdl/lbpg_checker.sv @@
// Port-level checks for the LED blink generator, bound to its top level.
`default_nettype none

module lbpg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic item_valid,
  input wire logic item_stall,
  input wire logic result_valid,
  input wire logic result_stall,
  input wire logic led0_lit,
  input wire logic led1_lit
);

  // No beat pending right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // Input side stalls only behind a stalled, full result stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without result back-pressure");

  // After an accepted beat the input stage is full: stall tracks result back-pressure.
  a_stage_full: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (item_stall == (result_valid && result_stall)))
    else $error("input stage lost an accepted beat");

  // A stalled result holds its LED levels.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> ($stable(led0_lit) && $stable(led1_lit)))
    else $error("LED levels changed under stall");

  // LED levels move only with a new result beat.
  a_led_with_beat: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !($stable(led0_lit) && $stable(led1_lit))) |-> result_valid)
    else $error("LED level changed without a result beat");

endmodule

bind led_blink_pattern_generator_unit lbpg_checker u_lbpg_checker (.*);

`default_nettype wire
